// ===== rtl/fmc_pkg.sv =====
// Package for the force magnitude cap unit: widths, register map and the
// item control struct shared by all pipeline sections. No dependencies.
package fmc_pkg;

   localparam int CompW    = 32;
   localparam int NumComp  = 6;
   localparam int NumAxis  = 3;
   localparam int CapW     = 31;
   localparam int SumW     = CompW + 1;
   localparam int SquareW  = 2 * SumW - 1;
   localparam int SqW      = SquareW + 2;
   localparam int RootW    = 34;
   localparam int RadW     = 2 * RootW;
   localparam int RemW     = RootW + 3;
   localparam int ScaleFrac = 24;
   localparam int ScaleW   = ScaleFrac + 1;
   localparam int DivRemW  = RootW + 1;
   localparam int ProdW    = CompW + ScaleW;
   localparam int CapSqW   = 2 * CapW;
   localparam int PaddrW   = 3;
   localparam int PdataW   = 32;

   // Register map, by byte address bit 2 (index of the register).
   localparam logic RegMaxForce = 1'b0;
   localparam logic [CapW-1:0] MaxForceReset = {CapW{1'b1}};

   typedef logic [NumComp-1:0][CompW-1:0] comp_vec_type;

   typedef struct packed {
      logic         valid;
      logic         capped;
      comp_vec_type comp;
   } item_ctl_type;

endpackage

// ===== rtl/fmc_if.sv =====
// Handshake interfaces for the force magnitude cap unit's input and result
// channels. Depends on fmc_pkg for field widths.
interface fmc_req_if;
   import fmc_pkg::*;
   logic              valid;
   logic              ready;
   logic [CompW-1:0]  inter_x;
   logic [CompW-1:0]  inter_y;
   logic [CompW-1:0]  inter_z;
   logic [CompW-1:0]  intra_x;
   logic [CompW-1:0]  intra_y;
   logic [CompW-1:0]  intra_z;
   modport source (output valid, inter_x, inter_y, inter_z, intra_x, intra_y, intra_z,
                   input ready);
   modport sink (input valid, inter_x, inter_y, inter_z, intra_x, intra_y, intra_z,
                 output ready);
endinterface

interface fmc_rsp_if;
   import fmc_pkg::*;
   logic              valid;
   logic              ready;
   logic [CompW-1:0]  out_inter_x;
   logic [CompW-1:0]  out_inter_y;
   logic [CompW-1:0]  out_inter_z;
   logic [CompW-1:0]  out_intra_x;
   logic [CompW-1:0]  out_intra_y;
   logic [CompW-1:0]  out_intra_z;
   logic              was_capped;
   modport source (output valid, out_inter_x, out_inter_y, out_inter_z, out_intra_x,
                   out_intra_y, out_intra_z, was_capped, input ready);
   modport sink (input valid, out_inter_x, out_inter_y, out_inter_z, out_intra_x,
                 out_intra_y, out_intra_z, was_capped, output ready);
endinterface

// ===== rtl/fmc_front.sv =====
// Front section: vector sums, squares, squared magnitude and cap compare.
// Four register stages. Depends on fmc_pkg.
module fmc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  fmc_pkg::comp_vec_type         in_comp,
   input  logic [fmc_pkg::CapSqW-1:0]    cap_sq,
   output fmc_pkg::item_ctl_type         out_ctl,
   output logic [fmc_pkg::SqW-1:0]       out_sq
);
   import fmc_pkg::*;

   item_ctl_type               s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic [NumAxis-1:0][SumW-1:0]    s1_sum_ff;
   logic [NumAxis-1:0][SquareW-1:0] s2_square_ff;
   logic [SqW-1:0]             s3_sq_ff, s4_sq_ff;
   logic [NumAxis-1:0][SumW-1:0]    sum_in;
   logic [NumAxis-1:0][SquareW-1:0] square_in;
   logic [NumAxis-1:0][SumW-1:0]    mag;
   logic [SqW-1:0]             sq_in;

   always_comb begin
      for (int a = 0; a < NumAxis; a++) begin
         sum_in[a] = {in_comp[a][CompW-1], in_comp[a]}
                   + {in_comp[a+NumAxis][CompW-1], in_comp[a+NumAxis]};
         mag[a] = s1_sum_ff[a][SumW-1] ? (~s1_sum_ff[a] + 1'b1) : s1_sum_ff[a];
         square_in[a] = SquareW'(mag[a] * mag[a]);
      end
      sq_in = SqW'(s2_square_ff[0]) + SqW'(s2_square_ff[1]) + SqW'(s2_square_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         s4_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ctl_ff.valid <= in_valid;
         s2_ctl_ff.valid <= s1_ctl_ff.valid;
         s3_ctl_ff.valid <= s2_ctl_ff.valid;
         s4_ctl_ff.valid <= s3_ctl_ff.valid;
      end
      if (adv) begin
         s1_ctl_ff.capped <= 1'b0;
         s1_ctl_ff.comp   <= in_comp;
         s1_sum_ff        <= sum_in;
         s2_ctl_ff.capped <= 1'b0;
         s2_ctl_ff.comp   <= s1_ctl_ff.comp;
         s2_square_ff     <= square_in;
         s3_ctl_ff.capped <= 1'b0;
         s3_ctl_ff.comp   <= s2_ctl_ff.comp;
         s3_sq_ff         <= sq_in;
         s4_ctl_ff.capped <= (s3_sq_ff >= SqW'(cap_sq));
         s4_ctl_ff.comp   <= s3_ctl_ff.comp;
         s4_sq_ff         <= s3_sq_ff;
      end
   end

   assign out_ctl = s4_ctl_ff;
   assign out_sq  = s4_sq_ff;
endmodule

// ===== rtl/fmc_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on fmc_pkg.
module fmc_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  fmc_pkg::item_ctl_type      in_ctl,
   input  logic [fmc_pkg::SqW-1:0]    in_sq,
   output fmc_pkg::item_ctl_type      out_ctl,
   output logic [fmc_pkg::RootW-1:0]  out_root
);
   import fmc_pkg::*;

   item_ctl_type      ctl_ff  [RootW+1];
   logic [RadW-1:0]   rad_ff  [RootW+1];
   logic [RemW-1:0]   rem_ff  [RootW+1];
   logic [RootW-1:0]  root_ff [RootW+1];

   assign ctl_ff[0]  = in_ctl;
   assign rad_ff[0]  = RadW'(in_sq);
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;

   for (genvar k = 0; k < RootW; k++) begin : g_step
      logic [RemW-1:0]  cur_in;
      logic [RemW-1:0]  trial_in;
      logic             take_in;

      always_comb begin
         cur_in   = {rem_ff[k][RemW-3:0], rad_ff[k][RadW-1 -: 2]};
         trial_in = {1'b0, root_ff[k], 2'b01};
         take_in  = (cur_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k+1].valid <= ctl_ff[k].valid;
         end
         if (adv) begin
            ctl_ff[k+1].capped <= ctl_ff[k].capped;
            ctl_ff[k+1].comp   <= ctl_ff[k].comp;
            rad_ff[k+1]  <= {rad_ff[k][RadW-3:0], 2'b00};
            rem_ff[k+1]  <= take_in ? (cur_in - trial_in) : cur_in;
            root_ff[k+1] <= {root_ff[k][RootW-2:0], take_in};
         end
      end
   end

   assign out_ctl  = ctl_ff[RootW];
   assign out_root = root_ff[RootW];
endmodule

// ===== rtl/fmc_div.sv =====
// Pipelined restoring divider forming the scale cap * 2^24 / magnitude,
// one quotient bit per register stage. Depends on fmc_pkg.
module fmc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [fmc_pkg::CapW-1:0]   cap,
   input  fmc_pkg::item_ctl_type      in_ctl,
   input  logic [fmc_pkg::RootW-1:0]  in_mag,
   output fmc_pkg::item_ctl_type      out_ctl,
   output logic [fmc_pkg::ScaleW-1:0] out_scale
);
   import fmc_pkg::*;

   item_ctl_type       ctl_ff  [ScaleW+1];
   logic [RootW-1:0]   mag_ff  [ScaleW+1];
   logic [DivRemW-1:0] rem_ff  [ScaleW+1];
   logic [ScaleW-1:0]  quot_ff [ScaleW+1];

   // The quotient is at most 2^24 because the magnitude is never below the
   // cap when capped, so the top dividend bits start out as the remainder.
   assign ctl_ff[0]  = in_ctl;
   assign mag_ff[0]  = in_mag;
   assign rem_ff[0]  = DivRemW'(cap[CapW-1:1]);
   assign quot_ff[0] = '0;

   for (genvar j = 0; j < ScaleW; j++) begin : g_step
      logic [DivRemW-1:0] cur_in;
      logic               take_in;

      always_comb begin
         cur_in  = {rem_ff[j][DivRemW-2:0], (j == 0) ? cap[0] : 1'b0};
         take_in = (cur_in >= DivRemW'(mag_ff[j]));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j+1].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[j+1].valid <= ctl_ff[j].valid;
         end
         if (adv) begin
            ctl_ff[j+1].capped <= ctl_ff[j].capped;
            ctl_ff[j+1].comp   <= ctl_ff[j].comp;
            mag_ff[j+1]  <= mag_ff[j];
            rem_ff[j+1]  <= take_in ? (cur_in - DivRemW'(mag_ff[j])) : cur_in;
            quot_ff[j+1] <= {quot_ff[j][ScaleW-2:0], take_in};
         end
      end
   end

   // A zero magnitude (zero cap and zero sum) yields a zero scale.
   assign out_ctl   = ctl_ff[ScaleW];
   assign out_scale = (mag_ff[ScaleW] == '0) ? '0 : quot_ff[ScaleW];
endmodule

// ===== rtl/fmc_scale.sv =====
// Output section: six scaling multipliers, truncation toward zero and the
// result register. Two register stages. Depends on fmc_pkg.
module fmc_scale (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  fmc_pkg::item_ctl_type      in_ctl,
   input  logic [fmc_pkg::ScaleW-1:0] in_scale,
   output fmc_pkg::item_ctl_type      out_ctl
);
   import fmc_pkg::*;

   item_ctl_type                    p_ctl_ff, o_ctl_ff;
   logic [NumComp-1:0][ProdW-1:0]   prod_ff;
   logic [NumComp-1:0][ProdW-1:0]   prod_in;
   logic [NumComp-1:0][CompW-1:0]   abs_v;
   comp_vec_type                    res_in;
   logic [CompW-1:0]                trunc;

   always_comb begin
      for (int c = 0; c < NumComp; c++) begin
         abs_v[c]   = in_ctl.comp[c][CompW-1] ? (~in_ctl.comp[c] + 1'b1) : in_ctl.comp[c];
         prod_in[c] = ProdW'(abs_v[c]) * ProdW'(in_scale);
      end
      res_in = p_ctl_ff.comp;
      for (int c = 0; c < NumComp; c++) begin
         trunc = prod_ff[c][ScaleFrac +: CompW];
         if (p_ctl_ff.capped) begin
            res_in[c] = p_ctl_ff.comp[c][CompW-1] ? (~trunc + 1'b1) : trunc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff.valid <= 1'b0;
         o_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         p_ctl_ff.valid <= in_ctl.valid;
         o_ctl_ff.valid <= p_ctl_ff.valid;
      end
      if (adv) begin
         p_ctl_ff.capped <= in_ctl.capped;
         p_ctl_ff.comp   <= in_ctl.comp;
         prod_ff         <= prod_in;
         o_ctl_ff.capped <= p_ctl_ff.capped;
         o_ctl_ff.comp   <= res_in;
      end
   end

   assign out_ctl = o_ctl_ff;
endmodule

// ===== rtl/force_magnitude_cap_unit.sv =====
// Force magnitude cap unit. Each transaction on req_ch carries one atom's
// intermolecular and intramolecular force vectors (signed Q16.16). The unit
// adds them, takes the magnitude of the sum and, when it reaches the cap in
// max_force, scales both vectors by cap/|sum| and sets was_capped.
// One result transaction leaves on rsp_ch for each input transaction, in order.
// Pipeline: 4 front stages, 34 square root stages, one root bit each, 25 divider
// stages, one scale bit each, and 2 multiply/output stages. Throughput: one
// transaction per cycle while rsp_ch does not stall.
// The whole pipeline advances together; while rsp_ch holds a result that the
// receiver does not take, the pipeline freezes and req_ch ready drops, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// The csr port is APB-style with one register, max_force, at byte address 0
// (low 31 bits used). Write it only while the pipeline is empty.
// Reset (synchronous) clears all valid bits and sets max_force to its
// largest value.
// Depends on fmc_pkg, fmc_if, fmc_front, fmc_sqrt, fmc_div and fmc_scale.
module force_magnitude_cap_unit (
   input  logic                         clock,
   input  logic                         reset,
   fmc_req_if.sink                      req_ch,
   fmc_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [fmc_pkg::PaddrW-1:0]   csr_paddr,
   input  logic [fmc_pkg::PdataW-1:0]   csr_pwdata,
   output logic [fmc_pkg::PdataW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import fmc_pkg::*;

   logic [CapW-1:0]    max_force_ff;
   logic [CapSqW-1:0]  cap_sq_ff;
   logic               adv;
   logic               reg_hit;
   comp_vec_type       in_comp;
   item_ctl_type       front_ctl, sqrt_ctl, div_ctl, out_ctl;
   logic [SqW-1:0]     front_sq;
   logic [RootW-1:0]   root;
   logic [ScaleW-1:0]  scale;

   assign reg_hit    = (csr_paddr[2] == RegMaxForce);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? PdataW'(max_force_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_force_ff <= MaxForceReset;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         max_force_ff <= csr_pwdata[CapW-1:0];
      end
      cap_sq_ff <= CapSqW'(max_force_ff) * CapSqW'(max_force_ff);
   end

   assign adv          = !out_ctl.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign in_comp = {req_ch.intra_z, req_ch.intra_y, req_ch.intra_x,
                     req_ch.inter_z, req_ch.inter_y, req_ch.inter_x};

   fmc_front u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_ch.valid),
      .in_comp(in_comp), .cap_sq(cap_sq_ff), .out_ctl(front_ctl), .out_sq(front_sq)
   );

   fmc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .adv(adv), .in_ctl(front_ctl), .in_sq(front_sq),
      .out_ctl(sqrt_ctl), .out_root(root)
   );

   fmc_div u_div (
      .clock(clock), .reset(reset), .adv(adv), .cap(max_force_ff), .in_ctl(sqrt_ctl),
      .in_mag(root), .out_ctl(div_ctl), .out_scale(scale)
   );

   fmc_scale u_scale (
      .clock(clock), .reset(reset), .adv(adv), .in_ctl(div_ctl), .in_scale(scale),
      .out_ctl(out_ctl)
   );

   assign rsp_ch.valid       = out_ctl.valid;
   assign rsp_ch.out_inter_x = out_ctl.comp[0];
   assign rsp_ch.out_inter_y = out_ctl.comp[1];
   assign rsp_ch.out_inter_z = out_ctl.comp[2];
   assign rsp_ch.out_intra_x = out_ctl.comp[3];
   assign rsp_ch.out_intra_y = out_ctl.comp[4];
   assign rsp_ch.out_intra_z = out_ctl.comp[5];
   assign rsp_ch.was_capped  = out_ctl.capped;

   // A stalled result must freeze the pipeline, including the input side.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input accepted while result stalled");

   // With a zero cap every magnitude reaches the cap.
   a_zero_cap_capped: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && max_force_ff == '0) |-> rsp_ch.was_capped)
      else $error("zero cap result not flagged as capped");

   // A capped zero-scale result carries all-zero vectors once it reaches
   // the output register.
   a_zero_scale_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && div_ctl.valid && div_ctl.capped && scale == '0) ##1 adv
      |=> (out_ctl.comp == '0))
      else $error("zero scale produced a nonzero vector");

endmodule

// ===== tb/sv/force_magnitude_cap_unit_tb.sv =====
// Testbench for the force magnitude cap unit: random and directed atom force
// transactions, checked against a behavioral model in a scoreboard class.
// Depends on fmc_pkg, fmc_if and the force_magnitude_cap_unit RTL.
`timescale 1ns / 1ps

typedef struct {
   logic [31:0] f [6];
   logic        capped;
} fmc_result_type;

class cap_scoreboard;
   fmc_result_type pending [$];
   logic [30:0] cap;
   int          errors;

   function new();
      cap = fmc_pkg::MaxForceReset;
      errors = 0;
   endfunction

   static function logic [31:0] scale_comp(logic signed [31:0] v, logic [24:0] scale);
      logic [63:0] mag;
      logic [63:0] p;
      mag = (v < 0) ? 64'(-64'(v)) : 64'(v);
      p = (mag * 64'(scale)) >> 24;
      if (v < 0) p = -p;
      return p[31:0];
   endfunction

   function void note_input(logic [31:0] f [6]);
      fmc_result_type r;
      logic signed [32:0] s;
      logic [67:0] sq;
      logic [67:0] cap_sq;
      logic [33:0] root;
      logic [33:0] trial;
      logic [63:0] scale;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         s = 33'($signed(f[i])) + 33'($signed(f[3+i]));
         sq += 68'($signed(s) * $signed(s));
      end
      cap_sq = 68'(cap) * 68'(cap);
      if (sq < cap_sq) begin
         r.f = f;
         r.capped = 1'b0;
      end else begin
         root = 0;
         for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if (68'(trial) * 68'(trial) <= sq) root = trial;
         end
         scale = (root == 0) ? 64'd0 : ({33'd0, cap} << 24) / 64'(root);
         for (int i = 0; i < 6; i++) r.f[i] = scale_comp(f[i], scale[24:0]);
         r.capped = 1'b1;
      end
      pending.push_back(r);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   task check_result(fmc_result_type got);
      fmc_result_type want;
      if (pending.size() == 0) begin
         report("unexpected transaction", 0, 0);
         return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 6; i++)
         if (got.f[i] !== want.f[i]) report($sformatf("component %0d", i), got.f[i], want.f[i]);
      if (got.capped !== want.capped) report("was_capped", 32'(got.capped), 32'(want.capped));
   endtask
endclass

module tb;
   import fmc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [PaddrW-1:0] csr_paddr = '0;
   logic [PdataW-1:0] csr_pwdata = '0;
   logic [PdataW-1:0] csr_prdata;
   logic csr_pready;

   fmc_req_if req_ch ();
   fmc_rsp_if rsp_ch ();

   cap_scoreboard force_board = new();

   force_magnitude_cap_unit dut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.inter_x, req_ch.inter_y, req_ch.inter_z} = '0;
      {req_ch.intra_x, req_ch.intra_y, req_ch.intra_z} = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic write_cap(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      force_board.cap = value[30:0];
   endtask

   task automatic send_atom(logic [31:0] f [6], bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.inter_x, req_ch.inter_y, req_ch.inter_z} <= {f[0], f[1], f[2]};
      {req_ch.intra_x, req_ch.intra_y, req_ch.intra_z} <= {f[3], f[4], f[5]};
      do @(posedge clock); while (!req_ch.ready);
      force_board.note_input(f);
   endtask

   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (force_board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(logic [30:0] cap);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $signed(32'($urandom_range(0, 2 * cap + 1))) - $signed({1'b0, cap});
         4: return 32'($urandom_range(0, 255)) - 32'd128;
         default: return $urandom() >>> $urandom_range(0, 31);
      endcase
   endfunction

   // Consumer side: random stalls per result, with stall-free stretches.
   initial begin
      fmc_result_type got;
      int stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.f[0] = rsp_ch.out_inter_x; got.f[1] = rsp_ch.out_inter_y;
         got.f[2] = rsp_ch.out_inter_z; got.f[3] = rsp_ch.out_intra_x;
         got.f[4] = rsp_ch.out_intra_y; got.f[5] = rsp_ch.out_intra_z;
         got.capped = rsp_ch.was_capped;
         force_board.check_result(got);
      end
   end

   initial begin
      logic [31:0] f [6];
      logic [31:0] caps [6];
      bit burst;
      caps = '{32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'd1, 32'h7FFF_FFFF, 32'h0100_0000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes under the reset cap, then exact-cap and zero-sum cases.
      foreach (f[i]) f[i] = 32'h7FFF_FFFF;
      send_atom(f, 1);
      foreach (f[i]) f[i] = 32'h8000_0000;
      send_atom(f, 0);
      foreach (f[i]) f[i] = 32'd0;
      send_atom(f, 0);
      f[0] = 32'h7FFF_FFFF; f[3] = 32'h8000_0000;
      send_atom(f, 1);
      drain_pipeline();
      write_cap(32'h8003_0000);
      foreach (f[i]) f[i] = 32'd0;
      f[0] = 32'h0001_0000; f[3] = 32'h0002_0000;
      send_atom(f, 0);
      f[0] = 32'h0001_0000; f[3] = 32'h0001_FFFF;
      send_atom(f, 0);
      f[1] = 32'hFFFE_0000; f[0] = 32'd0; f[3] = 32'd0; f[4] = 32'hFFFF_0000;
      send_atom(f, 0);
      drain_pipeline();
      write_cap(32'd0);
      foreach (f[i]) f[i] = 32'd0;
      send_atom(f, 0);
      f[0] = 32'd5; f[3] = 32'hFFFF_FFFB; f[1] = 32'h8000_0000; f[4] = 32'h7FFF_FFFF;
      send_atom(f, 0);
      f[1] = 32'h1234_5678;
      send_atom(f, 0);
      drain_pipeline();

      for (int phase = 0; phase < 6; phase++) begin
         write_cap(caps[phase] ^ (phase == 5 ? $urandom() & 32'h00FF_FFFF : 32'd0));
         for (int n = 0; n < 240; n++) begin
            burst = ($urandom_range(0, 5) == 0);
            foreach (f[i]) f[i] = pick_value(force_board.cap);
            send_atom(f, burst);
         end
         drain_pipeline();
      end
      write_cap(32'h8000_1234);
      drain_pipeline();
      if (force_board.errors == 0 && force_board.pending.size() == 0)
         $display("** force_magnitude_cap_unit: PASSED **");
      else
         $display("** force_magnitude_cap_unit: FAILED **");
      $finish;
   end

   initial begin
      #4ms;
      $display("** force_magnitude_cap_unit: FAILED **");
      $finish;
   end
endmodule
